>>> design/aes_pkg.sv
// aes_pkg: shared types, constants and byte functions for the aes-128 encrypt block
// depends on nothing; used by every module in design/
`default_nettype none

package aes_pkg;

    localparam int ROUND_COUNT = 10;
    localparam int RK_DEPTH    = ROUND_COUNT + 1;
    localparam int RK_AW       = $clog2(RK_DEPTH);
    localparam int BLK_W       = 128;
    localparam int HALF_W      = 64;

    localparam logic [7:0] RCON_INIT = 8'h01;
    localparam logic [7:0] GF_POLY   = 8'h1b;

    // configuration register indexes
    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    typedef logic [RK_AW-1:0] t_rk_addr;
    typedef logic [BLK_W-1:0] t_block;

    // round unit mode
    typedef struct packed {
        logic add_only;   // initial key addition
        logic last;       // final round, no column mix
    } t_round_ctl;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // multiply by x in gf(2^8)
    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
    endfunction

    // byte n of a block, byte 0 most significant
    function automatic logic [7:0] blk_byte(input t_block blk, input int n);
        return blk[BLK_W-1-8*n -: 8];
    endfunction

endpackage

`default_nettype wire

>>> design/aes_rk_ram.sv
// aes_rk_ram: round-key store, one 128-bit row per round key, registered read
// depends on aes_pkg
`default_nettype none

module aes_rk_ram (
    input  wire                  i_clk,
    input  wire                  i_we,
    input  wire                  i_re,
    input  aes_pkg::t_rk_addr    i_addr,
    input  aes_pkg::t_block      i_wdata,
    output aes_pkg::t_block      o_rdata
);

    aes_pkg::t_block r_mem [aes_pkg::RK_DEPTH];
    aes_pkg::t_block r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/aes_key_step.sv
// aes_key_step: derives the next round key from the current one
// depends on aes_pkg (sbox table)
`default_nettype none

module aes_key_step (
    input  aes_pkg::t_block  i_rk,
    input  wire [7:0]        i_rcon,
    output aes_pkg::t_block  o_rk
);

    logic [31:0] w0, w1, w2, w3, t;
    logic [31:0] n0, n1, n2, n3;

    always_comb begin
        {w0, w1, w2, w3} = i_rk;
        // rotword then subword, rcon into the top byte
        t = {aes_pkg::SBOX[w3[23:16]], aes_pkg::SBOX[w3[15:8]],
             aes_pkg::SBOX[w3[7:0]],   aes_pkg::SBOX[w3[31:24]]};
        t[31:24] = t[31:24] ^ i_rcon;
        n0 = w0 ^ t;
        n1 = w1 ^ n0;
        n2 = w2 ^ n1;
        n3 = w3 ^ n2;
    end

    assign o_rk = {n0, n1, n2, n3};

endmodule

`default_nettype wire

>>> design/aes_round.sv
// aes_round: one cipher round (subbytes, shiftrows, mixcolumns, addroundkey)
// depends on aes_pkg; mode chosen through aes_pkg::t_round_ctl
`default_nettype none

module aes_round (
    input  aes_pkg::t_block     i_state,
    input  aes_pkg::t_block     i_rk,
    input  aes_pkg::t_round_ctl i_ctl,
    output aes_pkg::t_block     o_state
);

    logic [7:0] s  [16];
    logic [7:0] ss [16];
    logic [7:0] mx [16];
    logic [7:0] a0, a1, a2, a3, all;
    aes_pkg::t_block pre;

    always_comb begin
        for (int n = 0; n < 16; n++) begin
            s[n] = aes_pkg::blk_byte(i_state, n);
        end
        // sub bytes with the row shift folded in
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                ss[c*4+r] = aes_pkg::SBOX[s[((c + r) % 4) * 4 + r]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0  = ss[4*c];
            a1  = ss[4*c+1];
            a2  = ss[4*c+2];
            a3  = ss[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            mx[4*c]   = a0 ^ all ^ aes_pkg::xtime(a0 ^ a1);
            mx[4*c+1] = a1 ^ all ^ aes_pkg::xtime(a1 ^ a2);
            mx[4*c+2] = a2 ^ all ^ aes_pkg::xtime(a2 ^ a3);
            mx[4*c+3] = a3 ^ all ^ aes_pkg::xtime(a3 ^ a0);
        end
        for (int n = 0; n < 16; n++) begin
            if (i_ctl.add_only) begin
                pre[aes_pkg::BLK_W-1-8*n -: 8] = s[n];
            end else if (i_ctl.last) begin
                pre[aes_pkg::BLK_W-1-8*n -: 8] = ss[n];
            end else begin
                pre[aes_pkg::BLK_W-1-8*n -: 8] = mx[n];
            end
        end
    end

    assign o_state = pre ^ i_rk;

endmodule

`default_nettype wire

>>> design/aes128_block_encrypt.sv
// aes128_block_encrypt: top level, sequencer around a shared round unit and round-key store
// depends on aes_pkg, aes_round, aes_key_step, aes_rk_ram
//
// channel    | direction | handshake              | payload
// -----------+-----------+------------------------+------------------------------------
// block in   | in        | start high, busy low   | i_plaintext_high, i_plaintext_low
// result     | out       | o_valid, one cycle     | o_ciphertext_high, o_ciphertext_low
// config     | in        | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// a transaction issues the first round-key read in S_LOAD, then makes
// eleven passes through the shared round unit (key addition, nine full rounds,
// final round), one per cycle, each reading one row of the round-key store
// after reset or any key write, the first transaction is preceded by a key
// expansion in S_EXPAND through the key-step unit, one round key per cycle
// reset (synchronous, active low) clears the key registers and marks the
// expansion pending; the key store itself is not cleared
// o_valid is a single-cycle strobe; the receiver cannot stall, and busy falls
// in the same cycle the result appears, so a new start can be taken right away
`default_nettype none

module aes128_block_encrypt (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [63:0] i_plaintext_high,
    input  wire  [63:0] i_plaintext_low,
    output logic        o_valid,
    output logic [63:0] o_ciphertext_high,
    output logic [63:0] o_ciphertext_low,
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire  [63:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXPAND = 4'b0010,
        S_LOAD   = 4'b0100,
        S_ROUND  = 4'b1000
    } t_state;

    localparam aes_pkg::t_rk_addr LAST_RK = aes_pkg::RK_AW'(aes_pkg::ROUND_COUNT);

    t_state             r_state, n_state;
    logic               r_pending, n_pending;
    logic [63:0]        r_key_high, r_key_low;
    aes_pkg::t_rk_addr  r_cnt, n_cnt;
    aes_pkg::t_block    r_blk, n_blk;
    aes_pkg::t_block    r_kexp, n_kexp;
    logic [7:0]         r_rcon, n_rcon;
    logic               r_valid, n_valid;
    aes_pkg::t_block    r_out, n_out;

    // datapath wiring
    aes_pkg::t_block    kstep_out;
    aes_pkg::t_block    round_out;
    aes_pkg::t_block    rk_rdata;
    aes_pkg::t_round_ctl round_ctl;
    logic               ram_we, ram_re;
    aes_pkg::t_rk_addr  ram_addr;

    assign round_ctl.add_only = (r_cnt == '0);
    assign round_ctl.last     = (r_cnt == LAST_RK);

    aes_round u_round (
        .i_state (r_blk),
        .i_rk    (rk_rdata),
        .i_ctl   (round_ctl),
        .o_state (round_out)
    );

    aes_key_step u_key_step (
        .i_rk   (r_kexp),
        .i_rcon (r_rcon),
        .o_rk   (kstep_out)
    );

    aes_rk_ram u_rk_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (r_kexp),
        .o_rdata (rk_rdata)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_pending = r_pending;
        n_cnt     = r_cnt;
        n_blk     = r_blk;
        n_kexp    = r_kexp;
        n_rcon    = r_rcon;
        n_valid   = 1'b0;
        n_out     = r_out;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = r_cnt;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_blk = {i_plaintext_high, i_plaintext_low};
                    n_cnt = '0;
                    if (r_pending) begin
                        n_kexp  = {r_key_high, r_key_low};
                        n_rcon  = aes_pkg::RCON_INIT;
                        n_state = S_EXPAND;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_EXPAND: begin
                // write round key r_cnt, derive the next one
                ram_we = 1'b1;
                n_kexp = kstep_out;
                n_rcon = aes_pkg::xtime(r_rcon);
                if (r_cnt == LAST_RK) begin
                    n_pending = 1'b0;
                    n_state   = S_LOAD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_LOAD: begin
                // fetch round key 0 ahead of the first pass
                ram_re   = 1'b1;
                ram_addr = '0;
                n_cnt    = '0;
                n_state  = S_ROUND;
            end
            S_ROUND: begin
                n_blk = round_out;
                if (r_cnt == LAST_RK) begin
                    n_valid = 1'b1;
                    n_out   = round_out;
                    n_state = S_IDLE;
                end else begin
                    // prefetch the key for the next pass
                    ram_re   = 1'b1;
                    ram_addr = r_cnt + 1'b1;
                    n_cnt    = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // the user must let key writes arrive only while idle; the block does not enforce it
        if (i_cfg_we) begin
            n_pending = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pending  <= 1'b1;
            r_valid    <= 1'b0;
            r_cnt      <= '0;
            r_key_high <= '0;
            r_key_low  <= '0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_valid   <= n_valid;
            r_cnt     <= n_cnt;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    aes_pkg::CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                    aes_pkg::CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_blk  <= n_blk;
        r_kexp <= n_kexp;
        r_rcon <= n_rcon;
        r_out  <= n_out;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_ciphertext_high = r_out[aes_pkg::BLK_W-1 -: aes_pkg::HALF_W];
    assign o_ciphertext_low  = r_out[aes_pkg::HALF_W-1:0];

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// tb_top: self-checking bench for the aes-128 block encrypt core
// depends on aes_pkg (config register indexes) and aes128_block_encrypt
`timescale 1ns / 100ps

module tb_top;

    // kinds of row in the directed table
    typedef enum logic [1:0] {
        ROW_BLOCK,
        ROW_KEY_HIGH,
        ROW_KEY_LOW
    } t_row_kind;

    // one directed row: a block to encrypt or a key half to write
    // key rows carry their data in d_high; typed rows carry a known ciphertext
    typedef struct packed {
        t_row_kind      kind;
        logic [63:0]    d_high;
        logic [63:0]    d_low;
        logic           typed;
        logic [127:0]   want;
    } t_dir_row;

    localparam int DIR_ROWS      = 23;
    localparam int PHASE_BLOCKS  = 467;
    localparam int DRAIN_CYCLES  = 24;

    // directed stimulus: extremes, one-half key writes, published test vectors
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        // zero key straight out of reset, expansion from the cleared registers
        '{ROW_BLOCK, 64'h0000000000000000, 64'h0000000000000000, 1'b1,
          128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
        '{ROW_BLOCK, 64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, 128'h0},
        '{ROW_BLOCK, 64'h8000000000000000, 64'h0000000000000001, 1'b0, 128'h0},
        // only the high half written, low half still zero
        '{ROW_KEY_HIGH, 64'h0001020304050607, 64'h0, 1'b0, 128'h0},
        '{ROW_BLOCK, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0, 128'h0},
        // completes the fips-197 appendix c.1 key
        '{ROW_KEY_LOW, 64'h08090a0b0c0d0e0f, 64'h0, 1'b0, 128'h0},
        '{ROW_BLOCK, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
          128'h69c4e0d86a7b0430d8cdb78070b4c55a},
        // same block again, round keys must be reused as they are
        '{ROW_BLOCK, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
          128'h69c4e0d86a7b0430d8cdb78070b4c55a},
        // fips-197 appendix b example
        '{ROW_KEY_HIGH, 64'h2b7e151628aed2a6, 64'h0, 1'b0, 128'h0},
        '{ROW_KEY_LOW, 64'habf7158809cf4f3c, 64'h0, 1'b0, 128'h0},
        '{ROW_BLOCK, 64'h3243f6a8885a308d, 64'h313198a2e0370734, 1'b1,
          128'h3925841d02dc09fbdc118597196a0b32},
        // all-ones key
        '{ROW_KEY_HIGH, 64'hffffffffffffffff, 64'h0, 1'b0, 128'h0},
        '{ROW_KEY_LOW, 64'hffffffffffffffff, 64'h0, 1'b0, 128'h0},
        '{ROW_BLOCK, 64'h0000000000000000, 64'h0000000000000000, 1'b0, 128'h0},
        '{ROW_BLOCK, 64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, 128'h0},
        '{ROW_BLOCK, 64'ha5a5a5a5a5a5a5a5, 64'h5a5a5a5a5a5a5a5a, 1'b0, 128'h0},
        '{ROW_BLOCK, 64'h0000000000000001, 64'h8000000000000000, 1'b0, 128'h0},
        // back to the zero key by explicit writes
        '{ROW_KEY_HIGH, 64'h0000000000000000, 64'h0, 1'b0, 128'h0},
        '{ROW_KEY_LOW, 64'h0000000000000000, 64'h0, 1'b0, 128'h0},
        '{ROW_BLOCK, 64'h0000000000000000, 64'h0000000000000000, 1'b1,
          128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
        '{ROW_BLOCK, 64'h0000000000000000, 64'h0000000000000000, 1'b1,
          128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
        // low half only
        '{ROW_KEY_LOW, 64'hffffffffffffffff, 64'h0, 1'b0, 128'h0},
        '{ROW_BLOCK, 64'h5a5a5a5a5a5a5a5a, 64'ha5a5a5a5a5a5a5a5, 1'b0, 128'h0}
    };

    // clock, reset and dut ports, every driven one known from time zero
    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    logic [63:0]    i_plaintext_high = 64'h0;
    logic [63:0]    i_plaintext_low = 64'h0;
    logic           o_valid;
    logic [63:0]    o_ciphertext_high;
    logic [63:0]    o_ciphertext_low;
    logic           i_cfg_we = 1'b0;
    logic           i_cfg_idx = aes_pkg::CFG_KEY_HIGH;
    logic [63:0]    i_cfg_data = 64'h0;

    // bench state: key shadow, expected ciphertexts, s-box table, idle rate, error count
    logic [63:0]    key_high_reg = 64'h0;
    logic [63:0]    key_low_reg = 64'h0;
    logic [127:0]   ciphertext_q [$];
    logic [7:0]     sbox_lut [256];
    int             idle_pct = 20;
    int             mismatch_count = 0;

    aes128_block_encrypt dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_plaintext_high  (i_plaintext_high),
        .i_plaintext_low   (i_plaintext_low),
        .o_valid           (o_valid),
        .o_ciphertext_high (o_ciphertext_high),
        .o_ciphertext_low  (o_ciphertext_low),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data)
    );

    // 8 ns period, first rising edge at 4 ns
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor: plain aes-128, s-box derived from the field inverse
    // ------------------------------------------------------------------

    // multiply by x modulo x^8 + x^4 + x^3 + x + 1
    function automatic logic [7:0] gf_mul2(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i])
                acc ^= x;
            x = gf_mul2(x);
        end
        return acc;
    endfunction

    // s-box = affine map of the multiplicative inverse (zero maps to zero)
    task automatic fill_sbox;
        logic [7:0] inv;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++)
                if (gf_mul(x[7:0], y[7:0]) == 8'h01)
                    inv = y[7:0];
            sbox_lut[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                        ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        end
    endtask

    // full encryption of one block; byte 0 is the top byte of each 128-bit word
    function automatic logic [127:0] encrypt_block(input logic [127:0] key,
                                                   input logic [127:0] pt);
        logic [31:0]  w [44];
        logic [7:0]   st [16];
        logic [7:0]   sh [16];
        logic [7:0]   rcon;
        logic [31:0]  t;
        logic [7:0]   a0, a1, a2, a3, all;
        logic [127:0] ct;
        rcon = 8'h01;
        for (int i = 0; i < 4; i++)
            w[i] = key[127-32*i -: 32];
        for (int i = 4; i < 44; i++) begin
            t = w[i-1];
            if (i % 4 == 0) begin
                // rotate, substitute, fold in the round constant
                t = {sbox_lut[t[23:16]], sbox_lut[t[15:8]],
                     sbox_lut[t[7:0]], sbox_lut[t[31:24]]} ^ {rcon, 24'h0};
                rcon = gf_mul2(rcon);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int n = 0; n < 16; n++)
            st[n] = pt[127-8*n -: 8] ^ w[n/4][31-8*(n%4) -: 8];
        for (int rnd = 1; rnd <= 10; rnd++) begin
            // substitute and shift rows, state is column major
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    sh[c*4+r] = sbox_lut[st[((c + r) % 4)*4 + r]];
            if (rnd < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = sh[4*c];
                    a1 = sh[4*c+1];
                    a2 = sh[4*c+2];
                    a3 = sh[4*c+3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    sh[4*c]   = a0 ^ all ^ gf_mul2(a0 ^ a1);
                    sh[4*c+1] = a1 ^ all ^ gf_mul2(a1 ^ a2);
                    sh[4*c+2] = a2 ^ all ^ gf_mul2(a2 ^ a3);
                    sh[4*c+3] = a3 ^ all ^ gf_mul2(a3 ^ a0);
                end
            end
            for (int n = 0; n < 16; n++)
                st[n] = sh[n] ^ w[4*rnd + n/4][31-8*(n%4) -: 8];
        end
        for (int n = 0; n < 16; n++)
            ct[127-8*n -: 8] = st[n];
        return ct;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // mostly uniform, with a share of all-zero, all-one, single-bit and single-zero-bit words
    function automatic logic [63:0] pick_word();
        logic [63:0] v;
        case ($urandom_range(15))
            0:       v = 64'h0;
            1:       v = '1;
            2:       v = 64'h1 << $urandom_range(63);
            3:       v = ~(64'h1 << $urandom_range(63));
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // one block transaction; start is redrawn every cycle and stays low in
    // idle_pct percent of them, the block is taken at an edge with start
    // high and busy low
    task automatic send_block(input logic [63:0] pt_high, input logic [63:0] pt_low,
                              input logic typed, input logic [127:0] want);
        i_plaintext_high <= pt_high;
        i_plaintext_low <= pt_low;
        do begin
            start <= ($urandom_range(99) >= idle_pct);
            @(posedge i_clk);
        end while (!(start && !busy));
        if (typed)
            ciphertext_q.push_back(want);
        else
            ciphertext_q.push_back(encrypt_block({key_high_reg, key_low_reg},
                                                 {pt_high, pt_low}));
    endtask

    // stop issuing and wait until every expected ciphertext has come back
    task automatic drain_blocks;
        start <= 1'b0;
        do @(posedge i_clk); while (ciphertext_q.size() != 0 || busy);
    endtask

    // key register writes, only called with the core idle
    task automatic write_key(input logic do_high, input logic do_low,
                             input logic [63:0] k_high, input logic [63:0] k_low);
        if (do_high) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= aes_pkg::CFG_KEY_HIGH;
            i_cfg_data <= k_high;
            @(posedge i_clk);
            key_high_reg = k_high;
        end
        if (do_low) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= aes_pkg::CFG_KEY_LOW;
            i_cfg_data <= k_low;
            @(posedge i_clk);
            key_low_reg = k_low;
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string what);
        if (mismatch_count < 100)
            $display("%0t ns  mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // result checker: sampled mid-cycle so it never races the edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : result_check
        logic [127:0] want;
        if (i_rst_n && o_valid) begin
            if (ciphertext_q.size() == 0) begin
                note_mismatch("result with no transaction outstanding");
            end else begin
                want = ciphertext_q.pop_front();
                if (o_ciphertext_high !== want[127:64])
                    note_mismatch($sformatf("ciphertext_high got %h want %h",
                                            o_ciphertext_high, want[127:64]));
                if (o_ciphertext_low !== want[63:0])
                    note_mismatch($sformatf("ciphertext_low got %h want %h",
                                            o_ciphertext_low, want[63:0]));
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int sent;
        int seg;
        int mode;
        fill_sbox();

        // synchronous reset
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, light sender idling
        idle_pct = 20;
        for (int i = 0; i < DIR_ROWS; i++) begin
            case (DIR_TABLE[i].kind)
                ROW_BLOCK: begin
                    send_block(DIR_TABLE[i].d_high, DIR_TABLE[i].d_low,
                               DIR_TABLE[i].typed, DIR_TABLE[i].want);
                end
                ROW_KEY_HIGH: begin
                    drain_blocks();
                    write_key(1'b1, 1'b0, DIR_TABLE[i].d_high, 64'h0);
                end
                ROW_KEY_LOW: begin
                    drain_blocks();
                    write_key(1'b0, 1'b1, 64'h0, DIR_TABLE[i].d_high);
                end
                default: begin
                    note_mismatch("bad directed row");
                end
            endcase
        end

        // random part: three idling phases, key changed between segments
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 20 : (ph == 1) ? 79 : 0;
            sent = 0;
            while (sent < PHASE_BLOCKS) begin
                drain_blocks();
                mode = $urandom_range(5);
                case (mode)
                    3:       write_key(1'b1, 1'b0, pick_word(), 64'h0);
                    4:       write_key(1'b0, 1'b1, 64'h0, pick_word());
                    5:       write_key(1'b1, 1'b1, {64{$urandom_range(1) == 1}},
                                       {64{$urandom_range(1) == 1}});
                    default: write_key(1'b1, 1'b1, pick_word(), pick_word());
                endcase
                seg = $urandom_range(10, 60);
                for (int k = 0; k < seg; k++)
                    send_block(pick_word(), pick_word(), 1'b0, 128'h0);
                sent += seg;
            end
        end

        // let the last transactions come back, then watch for strays
        drain_blocks();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("aes128_block_encrypt verification clean");
        else
            $display("aes128_block_encrypt verification failed");
        $finish;
    end

    // hang guard
    initial begin
        #5_000_000;
        $display("aes128_block_encrypt verification failed");
        $finish;
    end

endmodule

>>> aes128_block_encrypt.f
design/aes_pkg.sv
design/aes_rk_ram.sv
design/aes_key_step.sv
design/aes_round.sv
design/aes128_block_encrypt.sv
bench/tb_top.sv
